### rtl/blocked_bloom_filter_core_macros.svh
// Assertion helpers for the filter core RTL file.
`ifndef BLOCKED_BLOOM_FILTER_CORE_MACROS_SVH
`define BLOCKED_BLOOM_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbf: next-cycle check failed");

`endif

### rtl/bbf_pkg.sv
`default_nettype none

package bbf_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_PROBE,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Probe count and hit counter width
    localparam int CNT_W = 5;

    // A step whose low STEP_LOW_BITS bits are all zero is bumped by one
    localparam int STEP_LOW_BITS = 5;

    // Output payload width, padded to a byte
    localparam int OUT_W = 8;

    localparam logic [CNT_W-1:0] PROBE_COUNT_RESET = 5'd4;

endpackage

`default_nettype wire

### rtl/blocked_bloom_filter_core.sv
`default_nettype none
// Blocked Bloom filter core.
// Requests arrive on the s_ channel: s_tdata carries the 64-bit hash, s_tuser the
// command (0 insert, 1 query). The low FILTER_SHIFT-BLOCK_SHIFT hash bits select
// one 2^BLOCK_SHIFT-bit block; the next two BLOCK_SHIFT-bit fields give the start
// position and the step of the probe sequence.
// Results leave on the m_ channel: already_set_count and all_present.
// The cfg_ channel writes probe_count (reset value 4); write it only while idle.
// Each request reads its block once, walks the probes through a single bit
// test-and-set unit at one probe per cycle, and writes the block back on insert.
// An item passes from acceptance through the read, load, probe, write (insert only)
// and done states to its result; the core then returns to idle for the next request.
// After reset the block clears all 2^(FILTER_SHIFT-BLOCK_SHIFT) blocks (2048 by default)
// of the store, one block per cycle; s_tready stays low meanwhile.
// The result sits in an output register; while the receiver stalls the core may
// take and process one more request, then waits with that result until the
// register frees.

`include "blocked_bloom_filter_core_macros.svh"

module blocked_bloom_filter_core #(
    parameter int FILTER_SHIFT = 20,
    parameter int BLOCK_SHIFT  = 9
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [63:0]                 s_tdata,   // [63:0] hash
    input  wire                         s_tuser,   // [0] command
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [bbf_pkg::OUT_W-1:0]   m_tdata,   // [4:0] already_set_count, [5] all_present
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [bbf_pkg::CNT_W-1:0]   cfg_data   // [4:0] probe_count
);

    localparam int INDEX_BITS = FILTER_SHIFT - BLOCK_SHIFT;
    localparam int IDX_W      = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam longint NUM_BLOCKS = 64'd1 << INDEX_BITS;
    localparam int BLK_BITS   = 1 << BLOCK_SHIFT;
    localparam int CW         = bbf_pkg::CNT_W;
    localparam int SL         = bbf_pkg::STEP_LOW_BITS;

    bbf_pkg::state_t state_reg, state_next;

    logic [CW-1:0]          probe_count_reg, probe_count_next;
    logic [IDX_W-1:0]       clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]       addr_reg, addr_next;
    logic                   cmd_reg, cmd_next;
    logic [BLOCK_SHIFT-1:0] pos_reg, pos_next;
    logic [BLOCK_SHIFT-1:0] step_reg, step_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          hits_reg, hits_next;
    logic [BLK_BITS-1:0]    row_reg, row_next;
    logic                   m_valid_reg, m_valid_next;
    logic [bbf_pkg::OUT_W-1:0] m_data_reg, m_data_next;

    logic [BLK_BITS-1:0]    blocks [NUM_BLOCKS];
    logic [BLK_BITS-1:0]    rd_data_reg;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [BLK_BITS-1:0]    wr_data;

    logic [BLOCK_SHIFT-1:0] in_step;
    logic [IDX_W-1:0]       in_addr;

    assign s_tready  = (state_reg == bbf_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign in_addr = (INDEX_BITS > 0) ? s_tdata[IDX_W-1:0] : '0;

    always_comb
    begin
        in_step = s_tdata[FILTER_SHIFT +: BLOCK_SHIFT];
        if (in_step[SL-1:0] == '0)
        begin
            in_step = in_step + BLOCK_SHIFT'(1);
        end
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            blocks[wr_addr] <= wr_data;
        end
        rd_data_reg <= blocks[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bbf_pkg::ST_CLEAR;
            probe_count_reg <= bbf_pkg::PROBE_COUNT_RESET;
            clr_addr_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            probe_count_reg <= probe_count_next;
            clr_addr_reg    <= clr_addr_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        step_reg   <= step_next;
        idx_reg    <= idx_next;
        hits_reg   <= hits_next;
        row_reg    <= row_next;
        m_data_reg <= m_data_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        probe_count_next = probe_count_reg;
        clr_addr_next    = clr_addr_reg;
        addr_next        = addr_reg;
        cmd_next         = cmd_reg;
        pos_next         = pos_reg;
        step_next        = step_reg;
        idx_next         = idx_reg;
        hits_next        = hits_reg;
        row_next         = row_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        wr_en            = 1'b0;
        wr_addr          = addr_reg;
        wr_data          = row_reg;

        if (cfg_valid)
        begin
            probe_count_next = cfg_data;
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            bbf_pkg::ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(NUM_BLOCKS - 1))
                begin
                    state_next = bbf_pkg::ST_IDLE;
                end
            end
            bbf_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    addr_next  = in_addr;
                    cmd_next   = s_tuser;
                    pos_next   = s_tdata[INDEX_BITS +: BLOCK_SHIFT];
                    step_next  = in_step;
                    idx_next   = '0;
                    hits_next  = '0;
                    state_next = bbf_pkg::ST_READ;
                end
            end
            bbf_pkg::ST_READ:
            begin
                state_next = bbf_pkg::ST_LOAD;
            end
            bbf_pkg::ST_LOAD:
            begin
                row_next   = rd_data_reg;
                state_next = bbf_pkg::ST_PROBE;
            end
            bbf_pkg::ST_PROBE:
            begin
                if (idx_reg == probe_count_reg)
                begin
                    state_next = (cmd_reg == bbf_pkg::CMD_INSERT) ? bbf_pkg::ST_WRITE
                                                                  : bbf_pkg::ST_DONE;
                end
                else
                begin
                    // test one bit, set it on insert, advance along the step
                    if (row_reg[pos_reg])
                    begin
                        hits_next = hits_reg + CW'(1);
                    end
                    if (cmd_reg == bbf_pkg::CMD_INSERT)
                    begin
                        row_next[pos_reg] = 1'b1;
                    end
                    pos_next = pos_reg + step_reg;
                    idx_next = idx_reg + CW'(1);
                end
            end
            bbf_pkg::ST_WRITE:
            begin
                wr_en      = 1'b1;
                state_next = bbf_pkg::ST_DONE;
            end
            bbf_pkg::ST_DONE:
            begin
                // hold the result until the output register frees
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = bbf_pkg::OUT_W'({(hits_reg == probe_count_reg), hits_reg});
                    state_next   = bbf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bbf_pkg::ST_IDLE;
            end
        endcase
    end

    `BBF_ASSERT_NOW(a_write_states, clk, rst_n, wr_en,
        (state_reg == bbf_pkg::ST_CLEAR) || (state_reg == bbf_pkg::ST_WRITE))
    `BBF_ASSERT_NEXT(a_accept_reads, clk, rst_n, s_tvalid && s_tready,
        state_reg == bbf_pkg::ST_READ)
    `BBF_ASSERT_NOW(a_idx_bound, clk, rst_n, state_reg == bbf_pkg::ST_PROBE,
        idx_reg <= probe_count_reg)
    `BBF_ASSERT_NOW(a_hits_bound, clk, rst_n, state_reg == bbf_pkg::ST_PROBE,
        hits_reg <= idx_reg)

endmodule

`default_nettype wire

### tb/sv/bbf_checker.sv
`timescale 1ns / 100ps

module bbf_checker #(
    parameter int FILTER_SHIFT = 20,
    parameter int BLOCK_SHIFT  = 9
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        s_tvalid,
    input  wire                        s_tready,
    input  wire  [63:0]                s_tdata,   // [63:0] hash
    input  wire                        s_tuser,   // [0] command
    input  wire                        m_tvalid,
    input  wire                        m_tready,
    input  wire  [bbf_pkg::OUT_W-1:0]  m_tdata,   // [4:0] already_set_count, [5] all_present
    input  wire                        cfg_valid,
    input  wire                        cfg_ready,
    input  wire  [bbf_pkg::CNT_W-1:0]  cfg_data,  // [4:0] probe_count
    output int                         fail_count,
    output int                         pending_count,
    output int                         checked_count,
    output int                         hit_count
);

    localparam int INDEX_BITS = FILTER_SHIFT - BLOCK_SHIFT;
    localparam int NUM_BLOCKS = 1 << INDEX_BITS;
    localparam int BLK_BITS   = 1 << BLOCK_SHIFT;

    typedef struct packed {
        logic [bbf_pkg::CNT_W-1:0] set_count;
        logic                      all_set;
    } probe_result_t;

    logic [BLK_BITS-1:0]       filter_mem [NUM_BLOCKS];
    logic [bbf_pkg::CNT_W-1:0] probe_setting;
    probe_result_t             pending_results [$];

    initial
    begin
        for (int b = 0; b < NUM_BLOCKS; b++)
            filter_mem[b] = '0;
        probe_setting = bbf_pkg::PROBE_COUNT_RESET;
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
        hit_count     = 0;
    end

    // Walk the probe sequence of one request; mark the bits on insert.
    function automatic probe_result_t lookup_and_mark(input logic cmd, input logic [63:0] h);
        logic [INDEX_BITS-1:0]  blk;
        logic [BLOCK_SHIFT-1:0] pos;
        logic [BLOCK_SHIFT-1:0] step;
        logic [BLK_BITS-1:0]    row;
        int                     hits;
        probe_result_t          res;
        blk  = h[INDEX_BITS-1:0];
        pos  = h[INDEX_BITS +: BLOCK_SHIFT];
        step = h[FILTER_SHIFT +: BLOCK_SHIFT];
        if (step[bbf_pkg::STEP_LOW_BITS-1:0] == '0)
            step = step + BLOCK_SHIFT'(1);
        row  = filter_mem[blk];
        hits = 0;
        for (int i = 0; i < int'(probe_setting); i++)
        begin
            if (row[pos])
                hits++;
            if (cmd == bbf_pkg::CMD_INSERT)
                row[pos] = 1'b1;
            pos = pos + step;
        end
        filter_mem[blk] = row;
        res.set_count = hits[bbf_pkg::CNT_W-1:0];
        res.all_set   = (hits == int'(probe_setting));
        return res;
    endfunction

    always @(posedge clk)
    begin
        probe_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                probe_setting = cfg_data;
            // Retire the oldest result before taking a new request.
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result 0x%0h arrived with no request pending", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (m_tdata[bbf_pkg::CNT_W-1:0] !== want.set_count)
                    begin
                        $error("already_set_count: expected %0d, actual %0d",
                               want.set_count, m_tdata[bbf_pkg::CNT_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[bbf_pkg::CNT_W] !== want.all_set)
                    begin
                        $error("all_present: expected %0d, actual %0d",
                               want.all_set, m_tdata[bbf_pkg::CNT_W]);
                        fail_count++;
                    end
                    if (want.all_set)
                        hit_count++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = lookup_and_mark(s_tuser, s_tdata);
                pending_results = {pending_results, want};
            end
            pending_count = pending_results.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int FILTER_SHIFT  = 20;
    localparam int BLOCK_SHIFT   = 9;
    localparam int DRAIN_CYCLES  = 48;
    localparam int QUIET_LIMIT   = 8000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT       = 500;
    localparam int PHASE_ITEMS   = 255;
    localparam int POOL_DEPTH    = 64;

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [63:0]                s_tdata;   // [63:0] hash
    logic                       s_tuser;   // [0] command
    logic                       m_tvalid;
    logic                       m_tready;
    logic [bbf_pkg::OUT_W-1:0]  m_tdata;   // [4:0] already_set_count, [5] all_present
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [bbf_pkg::CNT_W-1:0]  cfg_data;  // [4:0] probe_count

    int fail_count;
    int pending_count;
    int checked_count;
    int hit_count;
    int settings_used;
    int quiet_cycles;
    int hold_left;
    bit hold_used;

    logic [63:0] hash_pool [$];

    blocked_bloom_filter_core #(
        .FILTER_SHIFT (FILTER_SHIFT),
        .BLOCK_SHIFT  (BLOCK_SHIFT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bbf_checker #(
        .FILTER_SHIFT (FILTER_SHIFT),
        .BLOCK_SHIFT  (BLOCK_SHIFT)
    ) checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .hit_count     (hit_count)
    );

    initial
        clk = 1'b0;

    always #10 clk = ~clk;

    // Neither side inserts random idles over this stretch of results.
    function automatic bit calm_window();
        return (checked_count >= 700) && (checked_count < 950);
    endfunction

    task automatic send_request(input logic cmd, input logic [63:0] h);
        @(negedge clk);
        while (!calm_window() && ($urandom_range(99) < 19))
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drop valid, wait for every result, then let the core settle.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_probe_count(input logic [bbf_pkg::CNT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [63:0] make_hash(input int blk, input int pos, input int step);
        logic [63:0] h;
        h = {$urandom(), $urandom()};
        h[10:0]  = blk[10:0];
        h[19:11] = pos[8:0];
        h[28:20] = step[8:0];
        return h;
    endfunction

    task automatic run_random_phase(input int count);
        logic [63:0] h;
        logic        cmd;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            cmd  = ($urandom_range(99) < 55) ? bbf_pkg::CMD_QUERY : bbf_pkg::CMD_INSERT;
            if (pick < 35 && hash_pool.size() != 0)
            begin
                // Revisit an inserted key so that queries hit.
                h   = hash_pool[$urandom_range(hash_pool.size() - 1)];
                cmd = ($urandom_range(99) < 70) ? bbf_pkg::CMD_QUERY : bbf_pkg::CMD_INSERT;
            end
            else if (pick < 70)
            begin
                // Crowd a few blocks to build up partial overlaps.
                h = {$urandom(), $urandom()};
                h[10:0] = $urandom_range(7);
            end
            else
            begin
                h = {$urandom(), $urandom()};
            end
            send_request(cmd, h);
            if (cmd == bbf_pkg::CMD_INSERT)
            begin
                hash_pool = {hash_pool, h};
                if (hash_pool.size() > POOL_DEPTH)
                    void'(hash_pool.pop_front());
            end
        end
        drain_results();
    endtask

    // Receiver: random backpressure, one long hold-off, one calm stretch.
    initial
    begin
        m_tready  = 1'b0;
        hold_left = 0;
        hold_used = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_used && checked_count >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= calm_window() || ($urandom_range(99) >= 19);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        int probe_plan [6];
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        quiet_cycles  = 0;
        settings_used = 1;
        rst_n         = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset probe count: empty filter, step bump, wrap at the top of a block.
        send_request(bbf_pkg::CMD_QUERY,  64'h0);
        send_request(bbf_pkg::CMD_INSERT, 64'h0);
        send_request(bbf_pkg::CMD_QUERY,  64'h0);
        send_request(bbf_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(bbf_pkg::CMD_QUERY,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(bbf_pkg::CMD_INSERT, make_hash(5, 0, 32));
        send_request(bbf_pkg::CMD_INSERT, make_hash(5, 500, 256));
        send_request(bbf_pkg::CMD_QUERY,  make_hash(5, 0, 33));
        send_request(bbf_pkg::CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(bbf_pkg::CMD_QUERY,  64'h5555_5555_5555_5555);
        drain_results();

        write_probe_count(5'd16);
        send_request(bbf_pkg::CMD_INSERT, 64'h0);
        send_request(bbf_pkg::CMD_QUERY,  64'h0);
        send_request(bbf_pkg::CMD_QUERY,  64'hFFFF_FFFF_FFFF_FFFF);
        drain_results();

        // Largest count with the shortest probe cycle the step allows.
        write_probe_count(5'd31);
        send_request(bbf_pkg::CMD_INSERT, make_hash(3, 0, 16));
        send_request(bbf_pkg::CMD_QUERY,  make_hash(3, 0, 16));
        send_request(bbf_pkg::CMD_INSERT, make_hash(3, 511, 511));
        drain_results();

        // No probes: nothing counted, always present, insert is a no-op.
        write_probe_count(5'd0);
        send_request(bbf_pkg::CMD_INSERT, make_hash(9, 17, 3));
        send_request(bbf_pkg::CMD_QUERY,  64'h0);
        drain_results();

        write_probe_count(5'd1);
        send_request(bbf_pkg::CMD_QUERY,  make_hash(9, 17, 3));
        send_request(bbf_pkg::CMD_QUERY,  64'h0);
        send_request(bbf_pkg::CMD_INSERT, make_hash(9, 17, 3));
        send_request(bbf_pkg::CMD_QUERY,  make_hash(9, 17, 3));
        drain_results();

        probe_plan = '{16, 1, 31, 8, 0, 0};
        probe_plan[4] = $urandom_range(1, 16);
        probe_plan[5] = $urandom_range(1, 16);
        foreach (probe_plan[p])
        begin
            write_probe_count(probe_plan[p][bbf_pkg::CNT_W-1:0]);
            run_random_phase(PHASE_ITEMS);
        end

        $display("Checked %0d results, %0d of them full hits, across %0d probe-count settings",
                 checked_count, hit_count, settings_used);
        $display("(0, 1, 16 and 31 among them), with a long receiver hold-off.");
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/bbf_pkg.sv
rtl/blocked_bloom_filter_core.sv
tb/sv/bbf_checker.sv
tb/sv/tb_top.sv
